/* sv/ddo_pkg.sv */
// Shared widths, register indexes, reset values, rotation constants and arithmetic
// helpers for the differential drive odometry block. No dependencies.
package ddo_pkg;

  localparam int CFG_W = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W = 32;
  localparam int US_W = 20;
  localparam int OUT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DIST_PER_TICK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_TRACK = 2'd1;

  localparam logic [CFG_W-1:0] DIST_PER_TICK_RST = 24'd281018;
  localparam logic [CFG_W-1:0] INV_TRACK_RST = 24'd91022;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_MAX = 30;
  localparam int STEP_W = 5;

  // Product register width, operand magnitude width, multiplier operand width.
  localparam int PW = 72;
  localparam int AW = 40;
  localparam int BW = 32;
  // Angle datapath width of the rotation unit.
  localparam int CW = 34;

  localparam int DIV_BITS = 52;
  localparam int DIV_CNT_W = 6;
  localparam logic [20:0] MICROS = 21'd1000000;
  localparam logic [DIV_BITS-1:0] HALF_MICROS = 52'd500000;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032875;
  localparam logic [BW-1:0] BAM_PER_RAD = 32'd683565276;

  function automatic logic signed [CW-1:0] atan_bam(input logic [STEP_W-1:0] i);
    logic signed [CW-1:0] a;
    case (i)
      5'd0: a = 34'sd536870912;
      5'd1: a = 34'sd316933406;
      5'd2: a = 34'sd167458908;
      5'd3: a = 34'sd85004756;
      5'd4: a = 34'sd42667331;
      5'd5: a = 34'sd21354465;
      5'd6: a = 34'sd10679838;
      5'd7: a = 34'sd5340245;
      5'd8: a = 34'sd2670163;
      5'd9: a = 34'sd1335087;
      5'd10: a = 34'sd667544;
      5'd11: a = 34'sd333772;
      5'd12: a = 34'sd166886;
      5'd13: a = 34'sd83443;
      5'd14: a = 34'sd41722;
      5'd15: a = 34'sd20861;
      5'd16: a = 34'sd10430;
      5'd17: a = 34'sd5215;
      5'd18: a = 34'sd2608;
      5'd19: a = 34'sd1304;
      5'd20: a = 34'sd652;
      5'd21: a = 34'sd326;
      5'd22: a = 34'sd163;
      5'd23: a = 34'sd81;
      5'd24: a = 34'sd41;
      5'd25: a = 34'sd20;
      5'd26: a = 34'sd10;
      5'd27: a = 34'sd5;
      5'd28: a = 34'sd3;
      5'd29: a = 34'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic [AW-1:0] mag(input logic signed [AW-1:0] v);
    logic [AW-1:0] m;
    m = v[AW-1] ? AW'(-v) : AW'(v);
    return m;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [PW-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > $signed(PW'(64'sh7FFFFFFF))) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -$signed(PW'(64'h80000000))) begin
      r = 32'sh80000000;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

/* sv/differential_drive_odometry.sv */
// Differential drive odometry: top level with the serial multiplier, divider,
// rotation unit and the sequencer that runs them. Depends on ddo_pkg.
//
// One word is taken at a time; in_stall stays high until its result has been
// written to the output register, which then holds it while the next word is
// worked on. The default is 16 rotations. There are eight shift-add
// multiplies, each after a load step. They retire one multiplier bit per
// cycle and stop once the remaining bits are zero (24, 24, 24, 20, 31, 31, 20
// and 30 bits at most). A restoring division by one million follows the fourth
// and the seventh multiply; the first division is followed by CORDIC_STEPS
// rotation steps (at most 30), and the output step comes after the last
// multiply. All multiplies share the single 72-bit product register.
// Configuration is always ready.
module differential_drive_odometry
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [CNT_W-1:0]     left_count,
  input  logic signed [CNT_W-1:0]     right_count,
  input  logic [US_W-1:0]             elapsed_us,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_W-1:0]     pos_x,
  output logic signed [OUT_W-1:0]     pos_y,
  output logic [OUT_W-1:0]            heading,
  output logic signed [OUT_W-1:0]     forward_rate,
  output logic signed [OUT_W-1:0]     turn_rate
);

  localparam int STEPS_EFF = (CORDIC_STEPS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STEPS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_CORD = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  localparam logic [2:0] PH_SUM    = 3'd0;
  localparam logic [2:0] PH_DIFF   = 3'd1;
  localparam logic [2:0] PH_TURN   = 3'd2;
  localparam logic [2:0] PH_FWDUS  = 3'd3;
  localparam logic [2:0] PH_DX     = 3'd4;
  localparam logic [2:0] PH_DY     = 3'd5;
  localparam logic [2:0] PH_TURNUS = 3'd6;
  localparam logic [2:0] PH_DTH    = 3'd7;

  localparam logic signed [PW-1:0] RND8  = 72'sd128;
  localparam logic signed [PW-1:0] RND9  = 72'sd256;
  localparam logic signed [PW-1:0] RND16 = 72'sd32768;
  localparam logic signed [PW-1:0] RND30 = 72'sd536870912;

  logic [2:0] state;
  logic [2:0] phase;

  logic [CFG_W-1:0] dist_per_tick;
  logic [CFG_W-1:0] inv_track;
  logic [CNT_W-1:0] prev_left;
  logic [CNT_W-1:0] prev_right;
  logic [OUT_W-1:0] acc_x;
  logic [OUT_W-1:0] acc_y;
  logic [OUT_W-1:0] acc_heading;
  logic             first_sample;

  logic signed [CNT_W:0]   sum;
  logic signed [CNT_W:0]   diff;
  logic [US_W-1:0]         us;
  logic signed [OUT_W-1:0] fwd;
  logic signed [OUT_W-1:0] dq;
  logic signed [OUT_W-1:0] turn;
  logic signed [CW-1:0]    travel;
  logic signed [CW-1:0]    rad;

  logic [PW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [PW-1:0] prod;
  logic          mul_neg;

  logic [DIV_BITS-1:0]  dreg;
  logic [19:0]          rem;
  logic [DIV_CNT_W-1:0] dcnt;

  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [CW-1:0] cz;
  logic                 cflip;
  logic [STEP_W-1:0]    cstep;

  logic signed [AW-1:0] ld_a;
  logic signed [AW-1:0] ld_b;
  logic signed [CW-1:0] cos_v;
  logic signed [CW-1:0] sin_v;
  logic signed [PW-1:0] prod_s;
  logic signed [PW-1:0] r8;
  logic signed [PW-1:0] r9;
  logic signed [PW-1:0] r16;
  logic signed [PW-1:0] r30;
  logic [20:0]          r2;
  logic signed [CW-1:0] quot_s;
  logic signed [CW-1:0] z0;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CNT_W-1:0] dl;
  logic signed [CNT_W-1:0] dr;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != ST_IDLE);

  assign dl = first_sample ? '0 : $signed(left_count - prev_left);
  assign dr = first_sample ? '0 : $signed(right_count - prev_right);

  assign cos_v = cflip ? -cx : cx;
  assign sin_v = cflip ? -cy : cy;

  always_comb begin
    unique case (phase)
      PH_SUM: begin
        ld_a = AW'(sum);
        ld_b = AW'($signed({1'b0, dist_per_tick}));
      end
      PH_DIFF: begin
        ld_a = AW'(diff);
        ld_b = AW'($signed({1'b0, dist_per_tick}));
      end
      PH_TURN: begin
        ld_a = AW'(dq);
        ld_b = AW'($signed({1'b0, inv_track}));
      end
      PH_FWDUS: begin
        ld_a = AW'(fwd);
        ld_b = AW'($signed({1'b0, us}));
      end
      PH_DX: begin
        ld_a = AW'(travel);
        ld_b = AW'(cos_v);
      end
      PH_DY: begin
        ld_a = AW'(travel);
        ld_b = AW'(sin_v);
      end
      PH_TURNUS: begin
        ld_a = AW'(turn);
        ld_b = AW'($signed({1'b0, us}));
      end
      default: begin
        ld_a = AW'(rad);
        ld_b = AW'($signed({1'b0, BAM_PER_RAD}));
      end
    endcase
  end

  assign prod_s = mul_neg ? -$signed(prod) : $signed(prod);
  assign r8  = (prod_s + RND8) >>> 8;
  assign r9  = (prod_s + RND9) >>> 9;
  assign r16 = (prod_s + RND16) >>> 16;
  assign r30 = (prod_s + RND30) >>> 30;

  assign r2 = {rem, dreg[DIV_BITS-1]};
  assign quot_s = mul_neg ? -$signed(CW'(dreg)) : $signed(CW'(dreg));

  assign z0 = CW'($signed(acc_heading));
  assign xs = cx >>> cstep;
  assign ys = cy >>> cstep;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_SUM;
      dist_per_tick <= DIST_PER_TICK_RST;
      inv_track <= INV_TRACK_RST;
      prev_left <= '0;
      prev_right <= '0;
      acc_x <= '0;
      acc_y <= '0;
      acc_heading <= '0;
      first_sample <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DIST_PER_TICK: dist_per_tick <= cfg_data;
          REG_INV_TRACK: inv_track <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            sum <= (CNT_W+1)'(dl) + (CNT_W+1)'(dr);
            diff <= (CNT_W+1)'(dl) - (CNT_W+1)'(dr);
            us <= elapsed_us;
            prev_left <= left_count;
            prev_right <= right_count;
            first_sample <= 1'b0;
            phase <= PH_SUM;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          mul_a <= PW'(mag(ld_a));
          mul_b <= BW'(mag(ld_b));
          mul_neg <= ld_a[AW-1] ^ ld_b[AW-1];
          prod <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_b != '0) begin
            if (mul_b[0]) begin
              prod <= prod + mul_a;
            end
            mul_a <= mul_a << 1;
            mul_b <= mul_b >> 1;
          end else begin
            case (phase)
              PH_SUM: begin
                fwd <= sat32(r9);
                phase <= PH_DIFF;
                state <= ST_LOAD;
              end
              PH_DIFF: begin
                dq <= sat32(r8);
                phase <= PH_TURN;
                state <= ST_LOAD;
              end
              PH_TURN: begin
                turn <= sat32(r16);
                phase <= PH_FWDUS;
                state <= ST_LOAD;
              end
              PH_DX: begin
                acc_x <= acc_x + r30[OUT_W-1:0];
                phase <= PH_DY;
                state <= ST_LOAD;
              end
              PH_DY: begin
                acc_y <= acc_y + r30[OUT_W-1:0];
                phase <= PH_TURNUS;
                state <= ST_LOAD;
              end
              PH_DTH: begin
                acc_heading <= acc_heading + r16[OUT_W-1:0];
                state <= ST_OUT;
              end
              default: begin
                dreg <= prod[DIV_BITS-1:0] + HALF_MICROS;
                rem <= '0;
                dcnt <= '0;
                state <= ST_DIV;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (dcnt == DIV_CNT_W'(DIV_BITS)) begin
            if (phase == PH_FWDUS) begin
              travel <= quot_s;
              if (z0 > $signed(CW'(34'sd1073741824))) begin
                cz <= z0 - $signed(CW'(34'sd2147483648));
                cflip <= 1'b1;
              end else if (z0 < -$signed(CW'(34'sd1073741824))) begin
                cz <= z0 + $signed(CW'(34'sd2147483648));
                cflip <= 1'b1;
              end else begin
                cz <= z0;
                cflip <= 1'b0;
              end
              cx <= CORDIC_GAIN;
              cy <= '0;
              cstep <= '0;
              state <= ST_CORD;
            end else begin
              rad <= quot_s;
              phase <= PH_DTH;
              state <= ST_LOAD;
            end
          end else begin
            if (r2 >= MICROS) begin
              rem <= 20'(r2 - MICROS);
              dreg <= {dreg[DIV_BITS-2:0], 1'b1};
            end else begin
              rem <= r2[19:0];
              dreg <= {dreg[DIV_BITS-2:0], 1'b0};
            end
            dcnt <= dcnt + 1'b1;
          end
        end
        ST_CORD: begin
          if (!cz[CW-1]) begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - atan_bam(cstep);
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + atan_bam(cstep);
          end
          cstep <= cstep + 1'b1;
          if (cstep == STEP_W'(STEPS_EFF - 1)) begin
            phase <= PH_DX;
            state <= ST_LOAD;
          end
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            pos_x <= acc_x;
            pos_y <= acc_y;
            heading <= acc_heading;
            forward_rate <= fwd;
            turn_rate <= turn;
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("sequencer did not leave idle after taking a word");
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_OUT)
    else $error("result word raised outside the output step");
  a_cordic_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_CORD |-> cstep < STEP_W'(STEPS_EFF))
    else $error("rotation step count ran past its limit");
`endif

endmodule

/* sim/ddo_checker.sv */
// Checker for the differential drive odometry block: watches the configuration,
// sample and result channels, predicts each result word and compares it.
// Depends on ddo_pkg.
`timescale 1ns / 1ps

module ddo_checker
  import ddo_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [CNT_W-1:0] left_count,
  input  logic signed [CNT_W-1:0] right_count,
  input  logic [US_W-1:0]         elapsed_us,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [OUT_W-1:0] pos_x,
  input  logic signed [OUT_W-1:0] pos_y,
  input  logic [OUT_W-1:0]        heading,
  input  logic signed [OUT_W-1:0] forward_rate,
  input  logic signed [OUT_W-1:0] turn_rate,
  output int                      errors,
  output int                      pending
);

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] hdg;
    logic [OUT_W-1:0] fwd;
    logic [OUT_W-1:0] turn;
  } pose_t;

  localparam int ROTATIONS = (CORDIC_STEPS_DEF < CORDIC_MAX) ? CORDIC_STEPS_DEF : CORDIC_MAX;
  localparam longint ONE_MILLION = 1000000;

  pose_t          pose_q[$];
  logic [CFG_W-1:0] dist_per_tick;
  logic [CFG_W-1:0] inv_track;
  logic [31:0]    last_left;
  logic [31:0]    last_right;
  logic [31:0]    x_acc;
  logic [31:0]    y_acc;
  logic [31:0]    hdg_acc;
  logic           priming;

  assign pending = pose_q.size();

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint round_micro(longint v);
    if (v >= 0) begin
      return (v + ONE_MILLION / 2) / ONE_MILLION;
    end
    return -((-v + ONE_MILLION / 2) / ONE_MILLION);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  task automatic rotate_heading(input logic [31:0] angle, output longint c, output longint s);
    longint z;
    longint x;
    longint y;
    longint xs;
    longint ys;
    bit     flip;
    z = longint'($signed(angle));
    x = longint'(CORDIC_GAIN);
    y = 0;
    flip = 0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < ROTATIONS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= longint'(atan_bam(STEP_W'(i)));
      end else begin
        x += ys;
        y -= xs;
        z += longint'(atan_bam(STEP_W'(i)));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_pose(input logic [31:0] l, input logic [31:0] r, input logic [19:0] us);
    longint dl;
    longint dr;
    longint sl;
    longint sr;
    longint fwd;
    longint dq;
    longint turn;
    longint travel;
    longint rad;
    longint dth;
    longint c;
    longint s;
    logic [31:0] diff;
    pose_t p;
    if (priming) begin
      last_left = l;
      last_right = r;
      priming = 0;
    end
    diff = l - last_left;
    dl = longint'($signed(diff));
    diff = r - last_right;
    dr = longint'($signed(diff));
    sl = dl * longint'(dist_per_tick);
    sr = dr * longint'(dist_per_tick);
    fwd = clamp32(round_shift(sl + sr, 9));
    dq = clamp32(round_shift(sl - sr, 8));
    turn = clamp32(round_shift(dq * longint'(inv_track), 16));
    rotate_heading(hdg_acc, c, s);
    travel = round_micro(fwd * longint'(us));
    x_acc += 32'(round_shift(travel * c, 30));
    y_acc += 32'(round_shift(travel * s, 30));
    rad = round_micro(turn * longint'(us));
    dth = round_shift(rad * longint'(BAM_PER_RAD), 16);
    hdg_acc += 32'(dth);
    last_left = l;
    last_right = r;
    p.x = x_acc;
    p.y = y_acc;
    p.hdg = hdg_acc;
    p.fwd = 32'(fwd);
    p.turn = 32'(turn);
    pose_q.push_back(p);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    pose_t p;
    if (rst) begin
      pose_q.delete();
      dist_per_tick = DIST_PER_TICK_RST;
      inv_track = INV_TRACK_RST;
      last_left = '0;
      last_right = '0;
      x_acc = '0;
      y_acc = '0;
      hdg_acc = '0;
      priming = 1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_DIST_PER_TICK) begin
          dist_per_tick = cfg_data;
        end else if (cfg_index == REG_INV_TRACK) begin
          inv_track = cfg_data;
        end
      end
      if (out_valid && !out_stall) begin
        if (pose_q.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected, actual x %h y %h", $realtime,
                   pos_x, pos_y);
        end else begin
          p = pose_q.pop_front();
          check_field("pos_x", p.x, pos_x);
          check_field("pos_y", p.y, pos_y);
          check_field("heading", p.hdg, heading);
          check_field("forward_rate", p.fwd, forward_rate);
          check_field("turn_rate", p.turn, turn_rate);
        end
      end
      if (in_valid && !in_stall) begin
        predict_pose(left_count, right_count, elapsed_us);
      end
    end
  end

endmodule

/* sim/differential_drive_odometry_tb.sv */
// Testbench top for the differential drive odometry block: drives samples and
// register writes with random idling and gives the verdict. Depends on
// ddo_pkg, ddo_checker and the block itself.
`timescale 1ns / 1ps

module differential_drive_odometry_tb
  import ddo_pkg::*;
;

  localparam int RANDOM_ITEMS = 1830;
  localparam int QUIET_ITEMS = 150;

  logic                    clk = 0;
  logic                    rst = 1;
  logic                    cfg_valid = 0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 0;
  logic                    in_stall;
  logic signed [CNT_W-1:0] left_count = '0;
  logic signed [CNT_W-1:0] right_count = '0;
  logic [US_W-1:0]         elapsed_us = '0;
  logic                    out_valid;
  logic                    out_stall = 0;
  logic signed [OUT_W-1:0] pos_x;
  logic signed [OUT_W-1:0] pos_y;
  logic [OUT_W-1:0]        heading;
  logic signed [OUT_W-1:0] forward_rate;
  logic signed [OUT_W-1:0] turn_rate;
  int                      errors;
  int                      pending;
  bit                      quiet = 0;
  logic [31:0]             left_now = '0;
  logic [31:0]             right_now = '0;

  differential_drive_odometry i_dut (.*);

  ddo_checker i_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (quiet) begin
        out_stall <= 0;
        @(posedge clk);
      end else begin
        out_stall <= $urandom_range(0, 2) == 0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  task automatic send_sample(logic [31:0] l, logic [31:0] r, logic [19:0] us);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1;
    left_count <= l;
    right_count <= r;
    elapsed_us <= us;
    left_now = l;
    right_now = r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic send_random;
    logic [31:0] l;
    logic [31:0] r;
    logic [19:0] us;
    int          mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      l = $urandom;
      r = $urandom;
    end else if (mode == 1) begin
      l = left_now + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      r = right_now + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    end else begin
      l = left_now + $urandom_range(0, 4000) - 2000;
      r = right_now + $urandom_range(0, 4000) - 2000;
    end
    us = ($urandom_range(0, 7) == 0) ? 20'($urandom) : 20'($urandom_range(1000, 100000));
    send_sample(l, r, us);
  endtask

  initial begin
    logic [CFG_W-1:0] dpt_set[6];
    logic [CFG_W-1:0] itw_set[6];
    dpt_set = '{DIST_PER_TICK_RST, 24'hFFFFFF, 24'd0, 24'd1, 24'h3FFFFF, 24'd281018};
    itw_set = '{INV_TRACK_RST, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd1, 24'h7FFFFF};
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_sample(32'h7FFF_FFF0, 32'h8000_0000, 20'd50000);
    send_sample(32'h8000_0010, 32'h7FFF_FFFF, 20'd50000);
    send_sample(32'h8000_0010, 32'h7FFF_FFFF, 20'd0);
    send_sample(32'h8000_1000, 32'h8000_0010, 20'hFFFFF);
    send_sample(32'h0000_0000, 32'hFFFF_FFFF, 20'hFFFFF);
    send_sample(32'hFFFF_FFFF, 32'h0000_0000, 20'd1);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'hFFFFF);
    send_sample(32'h0000_0000, 32'h0000_0000, 20'hFFFFF);
    send_sample(32'h0000_0100, 32'h0000_0080, 20'd100000);
    repeat (6) send_sample(left_now + 32'd400, right_now - 32'd300, 20'd200000);
    drain();
    write_reg(REG_DIST_PER_TICK, 24'hFFFFFF);
    write_reg(REG_INV_TRACK, 24'hFFFFFF);
    write_reg(2'd2, 24'h000000);
    write_reg(2'd3, 24'hFFFFFF);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 20'hFFFFF);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 20'hFFFFF);
    send_sample(32'h0000_0001, 32'h0000_0000, 20'hFFFFF);
    send_sample(32'h0000_0000, 32'h0000_0001, 20'hFFFFF);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_DIST_PER_TICK, (ph == 5) ? 24'($urandom) : dpt_set[ph]);
      write_reg(REG_INV_TRACK, (ph == 5) ? 24'($urandom) : itw_set[ph]);
      write_reg(2'($urandom_range(2, 3)), 24'($urandom));
      for (int k = 0; k < RANDOM_ITEMS / 6; k++) begin
        if (ph == 5 && k >= RANDOM_ITEMS / 6 - QUIET_ITEMS) begin
          quiet = 1;
        end
        send_random();
      end
      drain();
    end

    repeat (400) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* differential_drive_odometry.f */
sv/ddo_pkg.sv
sv/differential_drive_odometry.sv
sim/ddo_checker.sv
sim/differential_drive_odometry_tb.sv
